// ===== rtl/hzc_pkg.sv =====
package hzc_pkg;

   localparam int CordicSteps = 31;
   localparam int StepBits = 5;
   localparam logic signed [33:0] KGAIN = 34'sd652032874;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [31:0] HALF_TURN = 32'h8000_0000;

   // atan(2^-i) in 2^-32 turn units, rounded
   localparam logic [29:0] ATAN_TURN [CordicSteps] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
      30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
      30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1
   };

   typedef struct packed {
      logic signed [31:0] hour_angle;
      logic signed [31:0] declination;
   } req_type;

   typedef struct packed {
      logic [31:0]        azimuth;
      logic signed [31:0] elevation;
   } rsp_type;

   // rotation CORDIC vector: Q30 x, y and residual angle
   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
   } rot_type;

   // vectoring CORDIC vector: Q60 x, y and accumulated angle
   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [33:0] z;
   } vec_type;

   function automatic logic signed [33:0] atan_step(input logic [StepBits-1:0] idx);
      logic signed [33:0] t;
      t = $signed({4'b0000, ATAN_TURN[idx]});
      return t;
   endfunction

   // Q30 product, rounded half up
   function automatic logic signed [33:0] mulq(input logic signed [33:0] a,
                                               input logic signed [33:0] b);
      logic signed [67:0] p;
      p = 68'(a) * 68'(b) + 68'sd536870912;
      return p[63:30];
   endfunction

endpackage

// ===== rtl/hzc_rot_cell.sv =====
module hzc_rot_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [hzc_pkg::StepBits-1:0] step_idx,
   input  logic                         valid_in,
   input  hzc_pkg::rot_type             data_in,
   output logic                         valid_out,
   output hzc_pkg::rot_type             data_out
);

   logic             valid_ff;
   hzc_pkg::rot_type data_ff;
   hzc_pkg::rot_type data_in_c;
   logic signed [33:0] dx, dy, t;

   always_comb begin
      dx = data_in.x >>> step_idx;
      dy = data_in.y >>> step_idx;
      t  = hzc_pkg::atan_step(step_idx);
      if (!data_in.z[33]) begin
         data_in_c.x = data_in.x - dy;
         data_in_c.y = data_in.y + dx;
         data_in_c.z = data_in.z - t;
      end else begin
         data_in_c.x = data_in.x + dy;
         data_in_c.y = data_in.y - dx;
         data_in_c.z = data_in.z + t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in_c;
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

// ===== rtl/hzc_vec_cell.sv =====
module hzc_vec_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [hzc_pkg::StepBits-1:0] step_idx,
   input  logic                         valid_in,
   input  hzc_pkg::vec_type             data_in,
   output logic                         valid_out,
   output hzc_pkg::vec_type             data_out
);

   logic             valid_ff;
   hzc_pkg::vec_type data_ff;
   hzc_pkg::vec_type data_in_c;
   logic signed [63:0] dx, dy;
   logic signed [33:0] t;

   always_comb begin
      dx = data_in.x >>> step_idx;
      dy = data_in.y >>> step_idx;
      t  = hzc_pkg::atan_step(step_idx);
      if (!data_in.y[63]) begin
         data_in_c.x = data_in.x + dy;
         data_in_c.y = data_in.y - dx;
         data_in_c.z = data_in.z + t;
      end else begin
         data_in_c.x = data_in.x - dy;
         data_in_c.y = data_in.y + dx;
         data_in_c.z = data_in.z - t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in_c;
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

// ===== rtl/hadec_to_azel_convert_top.sv =====
// Hour angle / declination to azimuth / elevation converter. A request is taken
// in every cycle that start is high (busy stays low), and its result appears on
// rsp_data with rsp_strobe high for one cycle, in request order; the receiver
// must take it then. The pipeline is a chain of 31 rotation cells for the sines
// and cosines, a fix-up stage and two product stages, 31 vectoring cells for
// azimuth, a magnitude stage, 31 vectoring cells for elevation and the output
// register. Latitude is written through csr_we / csr_wdata and is sampled as
// each request enters.
module hadec_to_azel_convert_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  hzc_pkg::req_type   req_data,
   output logic               rsp_strobe,
   output hzc_pkg::rsp_type   rsp_data,
   input  logic               csr_we,
   input  logic signed [31:0] csr_wdata
);

   localparam int N = hzc_pkg::CordicSteps;
   localparam int Latency = 3 * N + 5;

   logic signed [31:0] latitude_ff;
   logic               accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         latitude_ff <= '0;
      end else if (csr_we) begin
         latitude_ff <= csr_wdata;
      end
   end

   // rotation lanes: hour angle, declination, latitude
   logic [31:0]      ang [3];
   logic [1:0]       quad_in [3];
   logic [31:0]      resid_in [3];
   hzc_pkg::rot_type rot_d [3][N+1];
   logic             rot_v [3][N+1];
   logic [1:0]       quad_line_ff [3][N];

   assign ang[0] = req_data.hour_angle;
   assign ang[1] = req_data.declination;
   assign ang[2] = latitude_ff;

   always_comb begin
      logic [31:0] biased;
      for (int l = 0; l < 3; l++) begin
         biased = ang[l] + 32'h2000_0000;
         quad_in[l] = biased[31:30];
         resid_in[l] = ang[l] - {quad_in[l], 30'b0};
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_lane
      assign rot_d[l][0] = '{x: hzc_pkg::KGAIN, y: '0, z: 34'(signed'(resid_in[l]))};
      assign rot_v[l][0] = accept;
      for (genvar k = 0; k < N; k++) begin : g_rot
         hzc_rot_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .step_idx  (hzc_pkg::StepBits'(k)),
            .valid_in  (rot_v[l][k]),
            .data_in   (rot_d[l][k]),
            .valid_out (rot_v[l][k+1]),
            .data_out  (rot_d[l][k+1])
         );
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 3; l++) begin
         quad_line_ff[l][0] <= quad_in[l];
         for (int k = 1; k < N; k++) begin
            quad_line_ff[l][k] <= quad_line_ff[l][k-1];
         end
      end
   end

   // rotate back by the quadrant
   logic signed [33:0] cos_ff [3];
   logic signed [33:0] sin_ff [3];
   logic               fix_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fix_v_ff <= 1'b0;
      end else begin
         fix_v_ff <= rot_v[0][N];
      end
      for (int l = 0; l < 3; l++) begin
         case (quad_line_ff[l][N-1])
            2'd0: begin
               cos_ff[l] <= rot_d[l][N].x;
               sin_ff[l] <= rot_d[l][N].y;
            end
            2'd1: begin
               cos_ff[l] <= -rot_d[l][N].y;
               sin_ff[l] <= rot_d[l][N].x;
            end
            2'd2: begin
               cos_ff[l] <= -rot_d[l][N].x;
               sin_ff[l] <= -rot_d[l][N].y;
            end
            default: begin
               cos_ff[l] <= rot_d[l][N].y;
               sin_ff[l] <= -rot_d[l][N].x;
            end
         endcase
      end
   end

   // first products
   logic signed [33:0] chcd_ff, sdcp_ff, sdsp_ff, shcd_ff, cp_ff, sp_ff;
   logic               p1_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
      end else begin
         p1_v_ff <= fix_v_ff;
      end
      chcd_ff <= hzc_pkg::mulq(cos_ff[0], cos_ff[1]);
      sdcp_ff <= hzc_pkg::mulq(sin_ff[1], cos_ff[2]);
      sdsp_ff <= hzc_pkg::mulq(sin_ff[1], sin_ff[2]);
      shcd_ff <= hzc_pkg::mulq(sin_ff[0], cos_ff[1]);
      cp_ff   <= cos_ff[2];
      sp_ff   <= sin_ff[2];
   end

   // horizon vector
   logic signed [33:0] hx_ff, hy_ff, hz_ff;
   logic               p2_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_v_ff <= 1'b0;
      end else begin
         p2_v_ff <= p1_v_ff;
      end
      hx_ff <= sdcp_ff - hzc_pkg::mulq(chcd_ff, sp_ff);
      hy_ff <= -shcd_ff;
      hz_ff <= hzc_pkg::mulq(chcd_ff, cp_ff) + sdsp_ff;
   end

   // azimuth vectoring chain
   hzc_pkg::vec_type az_d [N+1];
   logic             az_v [N+1];
   logic             zero_in, neg_in;
   logic             zero_line_ff [N];
   logic             neg_line_ff [N];
   logic signed [33:0] z_line_ff [N];
   logic signed [33:0] ax, ay;

   always_comb begin
      zero_in = (hx_ff == '0) && (hy_ff == '0);
      neg_in  = hx_ff[33];
      ax = neg_in ? -hx_ff : hx_ff;
      ay = neg_in ? -hy_ff : hy_ff;
      az_d[0].x = {ax, 30'b0};
      az_d[0].y = {ay, 30'b0};
      az_d[0].z = '0;
      az_v[0] = p2_v_ff;
   end

   for (genvar k = 0; k < N; k++) begin : g_az
      hzc_vec_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step_idx  (hzc_pkg::StepBits'(k)),
         .valid_in  (az_v[k]),
         .data_in   (az_d[k]),
         .valid_out (az_v[k+1]),
         .data_out  (az_d[k+1])
      );
   end

   always_ff @(posedge clock) begin
      zero_line_ff[0] <= zero_in;
      neg_line_ff[0]  <= neg_in;
      z_line_ff[0]    <= hz_ff;
      for (int k = 1; k < N; k++) begin
         zero_line_ff[k] <= zero_line_ff[k-1];
         neg_line_ff[k]  <= neg_line_ff[k-1];
         z_line_ff[k]    <= z_line_ff[k-1];
      end
   end

   // azimuth and horizontal magnitude
   logic [31:0]        azm_ff;
   logic signed [33:0] r_ff, zm_ff;
   logic               m_v_ff;
   logic signed [63:0] az_x;
   logic [31:0]        az_raw;

   assign az_x   = az_d[N].x;
   assign az_raw = az_d[N].z[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else begin
         m_v_ff <= az_v[N];
      end
      if (zero_line_ff[N-1]) begin
         azm_ff <= '0;
         r_ff   <= '0;
      end else begin
         azm_ff <= az_raw + (neg_line_ff[N-1] ? hzc_pkg::HALF_TURN : 32'h0);
         r_ff   <= hzc_pkg::mulq(az_x[63:30], hzc_pkg::KGAIN);
      end
      zm_ff <= z_line_ff[N-1];
   end

   // elevation vectoring chain
   hzc_pkg::vec_type el_d [N+1];
   logic             el_v [N+1];
   logic             deg_in;
   logic             deg_line_ff [N];
   logic [31:0]      az_line_ff [N];

   always_comb begin
      deg_in = (r_ff == '0) && (zm_ff == '0);
      el_d[0].x = {r_ff, 30'b0};
      el_d[0].y = {zm_ff, 30'b0};
      el_d[0].z = '0;
      el_v[0] = m_v_ff;
   end

   for (genvar k = 0; k < N; k++) begin : g_el
      hzc_vec_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step_idx  (hzc_pkg::StepBits'(k)),
         .valid_in  (el_v[k]),
         .data_in   (el_d[k]),
         .valid_out (el_v[k+1]),
         .data_out  (el_d[k+1])
      );
   end

   always_ff @(posedge clock) begin
      deg_line_ff[0] <= deg_in;
      az_line_ff[0]  <= azm_ff;
      for (int k = 1; k < N; k++) begin
         deg_line_ff[k] <= deg_line_ff[k-1];
         az_line_ff[k]  <= az_line_ff[k-1];
      end
   end

   // clamp and register the result
   logic signed [33:0] el_raw, quarter_pos, quarter_neg;
   logic               rsp_strobe_ff;
   hzc_pkg::rsp_type   rsp_data_ff;

   assign el_raw      = el_d[N].z;
   assign quarter_pos = $signed({2'b00, hzc_pkg::QUARTER_TURN});
   assign quarter_neg = -quarter_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= el_v[N];
      end
      rsp_data_ff.azimuth <= az_line_ff[N-1];
      if (deg_line_ff[N-1]) begin
         rsp_data_ff.elevation <= '0;
      end else if (el_raw > quarter_pos) begin
         rsp_data_ff.elevation <= quarter_pos[31:0];
      end else if (el_raw < quarter_neg) begin
         rsp_data_ff.elevation <= quarter_neg[31:0];
      end else begin
         rsp_data_ff.elevation <= el_raw[31:0];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##Latency rsp_strobe)
      else $error("request did not produce a result at the expected latency");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, Latency))
      else $error("result without a matching request");

   a_el_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.elevation <= 32'sh4000_0000)
                     && (rsp_data.elevation >= -32'sh4000_0000))
      else $error("elevation outside a quarter turn");

endmodule

// ===== bench/azel_checker.sv =====
`timescale 1ns / 1ps

module azel_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  hzc_pkg::req_type req_data,
   input  logic             rsp_strobe,
   input  hzc_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [31:0]      csr_wdata,
   output int               fail_count,
   output int               pending
);

   localparam longint GainQ30 = 652032874;
   localparam longint Quarter = 64'sd1073741824;

   logic [31:0]      lat_shadow;
   hzc_pkg::rsp_type azel_queue [$];

   function automatic longint turn_step(input int i);
      return longint'(hzc_pkg::ATAN_TURN[i]);
   endfunction

   function automatic longint q30_mul(input longint a, input longint b);
      return (a * b + (64'sd1 << 29)) >>> 30;
   endfunction

   function automatic void angle_sincos(input logic [31:0] a, output longint c,
                                        output longint s);
      logic [31:0] quad;
      logic [31:0] resid;
      longint x, y, z, nx;
      quad = ((a + 32'h2000_0000) >> 30) & 32'd3;
      resid = a - (quad << 30);
      z = longint'($signed(resid));
      x = GainQ30;
      y = 0;
      for (int i = 0; i < hzc_pkg::CordicSteps; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); y = y + (x >>> i); z -= turn_step(i);
         end else begin
            nx = x + (y >>> i); y = y - (x >>> i); z += turn_step(i);
         end
         x = nx;
      end
      case (quad)
         0: begin c = x; s = y; end
         1: begin c = -y; s = x; end
         2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic void vector_angle(input longint xi, input longint yi,
                                        output longint ang, output longint mag);
      longint x, y, z, nx;
      x = xi <<< 30;
      y = yi <<< 30;
      z = 0;
      for (int i = 0; i < hzc_pkg::CordicSteps; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i); y = y - (x >>> i); z += turn_step(i);
         end else begin
            nx = x - (y >>> i); y = y + (x >>> i); z -= turn_step(i);
         end
         x = nx;
      end
      ang = z;
      mag = x >>> 30;
   endfunction

   function automatic hzc_pkg::rsp_type predict_azel(input hzc_pkg::req_type rq,
                                                     input logic [31:0] lat);
      longint ch, sh, cd, sd, cp, sp, chcd, x, y, z, r, m, el, ang;
      logic [31:0] base;
      hzc_pkg::rsp_type res;
      angle_sincos(rq.hour_angle, ch, sh);
      angle_sincos(rq.declination, cd, sd);
      angle_sincos(lat, cp, sp);
      chcd = q30_mul(ch, cd);
      x = q30_mul(sd, cp) - q30_mul(chcd, sp);
      y = -q30_mul(sh, cd);
      z = q30_mul(chcd, cp) + q30_mul(sd, sp);
      if (x == 0 && y == 0) begin
         res.azimuth = '0;
         r = 0;
      end else begin
         base = '0;
         if (x < 0) begin
            x = -x; y = -y; base = hzc_pkg::HALF_TURN;
         end
         vector_angle(x, y, ang, m);
         res.azimuth = base + ang[31:0];
         r = q30_mul(m, GainQ30);
      end
      if (r == 0 && z == 0) begin
         el = 0;
      end else begin
         vector_angle(r, z, el, m);
         if (el > Quarter) el = Quarter;
         if (el < -Quarter) el = -Quarter;
      end
      res.elevation = el[31:0];
      return res;
   endfunction

   assign pending = azel_queue.size();

   always @(posedge clock) begin
      hzc_pkg::rsp_type want;
      if (reset) begin
         lat_shadow <= '0;
         azel_queue.delete();
         fail_count <= 0;
      end else begin
         if (rsp_strobe) begin
            if (azel_queue.size() == 0) begin
               $error("unexpected response az=%h el=%h", rsp_data.azimuth, rsp_data.elevation);
               fail_count <= fail_count + 1;
            end else begin
               want = azel_queue.pop_front();
               if (rsp_data.azimuth !== want.azimuth) begin
                  $error("azimuth expected %h actual %h", want.azimuth, rsp_data.azimuth);
                  fail_count <= fail_count + 1;
               end else if (rsp_data.elevation !== want.elevation) begin
                  $error("elevation expected %h actual %h", want.elevation, rsp_data.elevation);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // latitude is sampled as the request enters
         if (start && !busy) azel_queue.push_back(predict_azel(req_data, lat_shadow));
         if (csr_we) lat_shadow <= csr_wdata;
      end
   end
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int DrainCycles = 120;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   hzc_pkg::req_type req_data = '0;
   logic    rsp_strobe;
   hzc_pkg::rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic signed [31:0] csr_wdata = '0;
   int      fail_count;
   int      pending;

   always #2 clock = ~clock;

   hadec_to_azel_convert_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   azel_checker chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_wdata(csr_wdata), .fail_count(fail_count), .pending(pending)
   );

   function automatic logic [31:0] rand_angle();
      case ($urandom_range(0, 5))
         0: return 32'h4000_0000 * $urandom_range(0, 3) + $urandom_range(0, 8) - 4;
         1: return 32'h2000_0000 * $urandom_range(0, 7) + $urandom_range(0, 64) - 32;
         default: return $urandom;
      endcase
   endfunction

   // drive one request and hold until accepted
   task automatic send_request(input logic [31:0] ha, input logic [31:0] dec);
      start <= 1'b1;
      req_data <= '{hour_angle: ha, declination: dec};
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain_and_write(input logic [31:0] lat);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= lat;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   logic [31:0] edge_vals [8] = '{32'h0, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000,
                                  32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h2000_0000, 32'h0000_0001};
   logic [31:0] lat_list [7] = '{32'h0, 32'h4000_0000, 32'hC000_0000, 32'h7FFF_FFFF,
                                 32'h8000_0000, 32'h1555_5555, 32'hF000_0000};

   initial begin
      int burst;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int p = 0; p < 7; p++) begin
         drain_and_write(p < 6 ? lat_list[p] : $urandom);
         // zenith, nadir and quarter-turn extremes
         if (p < 3) begin
            for (int i = 0; i < 8; i++) send_request(edge_vals[i], edge_vals[(i * 3) % 8]);
         end
         for (int n = 0; n < 250; ) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++) begin
               send_request(rand_angle(), rand_angle());
               n++;
            end
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
         end
      end
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end
endmodule
